// ----- src/etp_pkg.sv -----
`default_nettype none
package etp_pkg;

   localparam int DEF_MAX_NODES = 1024;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [INDEX_W-1:0]  index_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam action_type ACT_BEGIN = 2'd0;
   localparam action_type ACT_ENTRY = 2'd1;
   localparam action_type ACT_READ  = 2'd2;

   localparam logic KIND_ATTACH = 1'b0;
   localparam logic KIND_ANSWER = 1'b1;

   localparam count_type ACTIVE_DIM_RESET = 11'd1024;

   typedef struct packed {
      logic link;
      logic top;
      logic par;
   } store_we_type;

endpackage
`default_nettype wire

// ----- src/etp_if.sv -----
`default_nettype none
interface etp_req_if;
   logic                 valid;
   logic                 ready;
   etp_pkg::action_type  action;
   etp_pkg::index_type   row_index;
   etp_pkg::index_type   col_index;
   etp_pkg::index_type   query_node;

   modport source (output valid, action, row_index, col_index, query_node, input ready);
   modport sink (input valid, action, row_index, col_index, query_node, output ready);
endinterface

interface etp_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   etp_pkg::index_type   child_node;
   etp_pkg::count_type   parent_node;

   modport source (output valid, kind, child_node, parent_node, input ready);
   modport sink (input valid, kind, child_node, parent_node, output ready);
endinterface

interface etp_csr_if;
   logic                 valid;
   logic                 ready;
   etp_pkg::count_type   active_dim;

   modport source (output valid, active_dim, input ready);
   modport sink (input valid, active_dim, output ready);
endinterface
`default_nettype wire

// ----- src/elimination_tree_parent.sv -----
`default_nettype none
// Elimination tree builder using union-find with path halving. Feed rows in ascending
// order: a begin-row item and an entry not below the diagonal finish in the idle
// state, a parent read passes the query and emit states, and a lower entry finds its
// root in the link state with a halve state per path-halving step, then visits the
// top and parent states and, when it attaches a subtree, the emit state, since all
// link, subtree and parent tables share one registered read address per cycle. The
// block accepts a new item only while idle; a finished result waits in the output
// register without holding up the next item; only a second one stalls the sequencer.
module elimination_tree_parent #(
   parameter int MAX_NODES = etp_pkg::DEF_MAX_NODES
) (
   input  wire        clock,
   input  wire        reset,
   etp_req_if.sink    req_bus,
   etp_rsp_if.source  rsp_bus,
   etp_csr_if.sink    csr_bus
);

   localparam int ADDR_W = $clog2(MAX_NODES);

   etp_pkg::count_type    active_dim_ff, active_dim_in;
   etp_pkg::store_we_type we;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     link_waddr, link_wdata;
   logic [ADDR_W-1:0]     top_waddr, top_wdata;
   logic [ADDR_W-1:0]     par_waddr;
   etp_pkg::count_type    par_wdata;
   logic [ADDR_W-1:0]     link_q, top_q;
   etp_pkg::count_type    par_q;

   assign csr_bus.ready = 1'b1;
   assign active_dim_in = csr_bus.valid ? csr_bus.active_dim : active_dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_dim_ff <= etp_pkg::ACTIVE_DIM_RESET;
      end else begin
         active_dim_ff <= active_dim_in;
      end
   end

   etp_seq #(.MAX_NODES(MAX_NODES)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .active_dim (active_dim_ff),
      .we         (we),
      .rd_addr    (rd_addr),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .top_waddr  (top_waddr),
      .top_wdata  (top_wdata),
      .par_waddr  (par_waddr),
      .par_wdata  (par_wdata),
      .link_q     (link_q),
      .top_q      (top_q),
      .par_q      (par_q)
   );

   etp_store #(.MAX_NODES(MAX_NODES)) u_store (
      .clock      (clock),
      .we         (we),
      .rd_addr    (rd_addr),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .top_waddr  (top_waddr),
      .top_wdata  (top_wdata),
      .par_waddr  (par_waddr),
      .par_wdata  (par_wdata),
      .link_q     (link_q),
      .top_q      (top_q),
      .par_q      (par_q)
   );

endmodule
`default_nettype wire

// ----- src/etp_store.sv -----
`default_nettype none
module etp_store #(
   parameter int MAX_NODES = etp_pkg::DEF_MAX_NODES
) (
   input  wire                         clock,
   input  etp_pkg::store_we_type       we,
   input  wire  [$clog2(MAX_NODES)-1:0] rd_addr,
   input  wire  [$clog2(MAX_NODES)-1:0] link_waddr,
   input  wire  [$clog2(MAX_NODES)-1:0] link_wdata,
   input  wire  [$clog2(MAX_NODES)-1:0] top_waddr,
   input  wire  [$clog2(MAX_NODES)-1:0] top_wdata,
   input  wire  [$clog2(MAX_NODES)-1:0] par_waddr,
   input  etp_pkg::count_type          par_wdata,
   output logic [$clog2(MAX_NODES)-1:0] link_q,
   output logic [$clog2(MAX_NODES)-1:0] top_q,
   output etp_pkg::count_type          par_q
);

   localparam int ADDR_W = $clog2(MAX_NODES);

   logic [ADDR_W-1:0]  link_mem [MAX_NODES];
   logic [ADDR_W-1:0]  top_mem  [MAX_NODES];
   etp_pkg::count_type par_mem  [MAX_NODES];

   always_ff @(posedge clock) begin
      if (we.link) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_q <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we.top) begin
         top_mem[top_waddr] <= top_wdata;
      end
      top_q <= top_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we.par) begin
         par_mem[par_waddr] <= par_wdata;
      end
      par_q <= par_mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- src/etp_seq.sv -----
`default_nettype none
module etp_seq #(
   parameter int MAX_NODES = etp_pkg::DEF_MAX_NODES
) (
   input  wire                          clock,
   input  wire                          reset,
   etp_req_if.sink                      req_bus,
   etp_rsp_if.source                    rsp_bus,
   input  etp_pkg::count_type           active_dim,
   output etp_pkg::store_we_type        we,
   output logic [$clog2(MAX_NODES)-1:0] rd_addr,
   output logic [$clog2(MAX_NODES)-1:0] link_waddr,
   output logic [$clog2(MAX_NODES)-1:0] link_wdata,
   output logic [$clog2(MAX_NODES)-1:0] top_waddr,
   output logic [$clog2(MAX_NODES)-1:0] top_wdata,
   output logic [$clog2(MAX_NODES)-1:0] par_waddr,
   output etp_pkg::count_type           par_wdata,
   input  wire  [$clog2(MAX_NODES)-1:0] link_q,
   input  wire  [$clog2(MAX_NODES)-1:0] top_q,
   input  etp_pkg::count_type           par_q
);

   localparam int ADDR_W = $clog2(MAX_NODES);
   localparam int STEP_W = $clog2(MAX_NODES + 1);
   localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_NODES);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_LINK  = 7'b0000010,
      S_HALVE = 7'b0000100,
      S_TOP   = 7'b0001000,
      S_PAR   = 7'b0010000,
      S_QRY   = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  x_ff, x_in;
   logic [ADDR_W-1:0]  rep_ff, rep_in;
   logic [ADDR_W-1:0]  top_ff, top_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   etp_pkg::index_type cur_row_ff, cur_row_in;
   logic [ADDR_W-1:0]  cur_rep_ff, cur_rep_in;
   logic               res_kind_ff, res_kind_in;
   etp_pkg::index_type res_child_ff, res_child_in;
   etp_pkg::count_type res_parent_ff, res_parent_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   etp_pkg::index_type rsp_child_ff, rsp_child_in;
   etp_pkg::count_type rsp_parent_ff, rsp_parent_in;

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_kind_ff;
   assign rsp_bus.child_node  = rsp_child_ff;
   assign rsp_bus.parent_node = rsp_parent_ff;

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      rep_in        = rep_ff;
      top_in        = top_ff;
      steps_in      = steps_ff;
      cur_row_in    = cur_row_ff;
      cur_rep_in    = cur_rep_ff;
      res_kind_in   = res_kind_ff;
      res_child_in  = res_child_ff;
      res_parent_in = res_parent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_child_in  = rsp_child_ff;
      rsp_parent_in = rsp_parent_ff;
      we            = '0;
      rd_addr       = x_ff;
      link_waddr    = x_ff;
      link_wdata    = link_q;
      top_waddr     = cur_rep_ff;
      top_wdata     = ADDR_W'(cur_row_ff);
      par_waddr     = top_ff;
      par_wdata     = etp_pkg::count_type'(cur_row_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               unique case (req_bus.action)
                  etp_pkg::ACT_BEGIN: begin
                     if ((etp_pkg::count_type'(req_bus.row_index) < active_dim) &&
                         (32'(req_bus.row_index) < MAX_NODES)) begin
                        we         = '{link: 1'b1, top: 1'b1, par: 1'b1};
                        link_waddr = ADDR_W'(req_bus.row_index);
                        link_wdata = ADDR_W'(req_bus.row_index);
                        top_waddr  = ADDR_W'(req_bus.row_index);
                        top_wdata  = ADDR_W'(req_bus.row_index);
                        par_waddr  = ADDR_W'(req_bus.row_index);
                        par_wdata  = active_dim;
                        cur_row_in = req_bus.row_index;
                        cur_rep_in = ADDR_W'(req_bus.row_index);
                     end
                  end
                  etp_pkg::ACT_ENTRY: begin
                     if (req_bus.col_index < cur_row_ff) begin
                        x_in     = ADDR_W'(req_bus.col_index);
                        rd_addr  = ADDR_W'(req_bus.col_index);
                        steps_in = '0;
                        state_in = S_LINK;
                     end
                  end
                  etp_pkg::ACT_READ: begin
                     res_kind_in  = etp_pkg::KIND_ANSWER;
                     res_child_in = req_bus.query_node;
                     if (32'(req_bus.query_node) < MAX_NODES) begin
                        rd_addr  = ADDR_W'(req_bus.query_node);
                        state_in = S_QRY;
                     end else begin
                        res_parent_in = active_dim;
                        state_in      = S_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LINK: begin
            if ((link_q == x_ff) || (steps_ff == STEP_LIMIT)) begin
               rep_in   = x_ff;
               rd_addr  = x_ff;
               state_in = S_TOP;
            end else begin
               rd_addr  = link_q;
               state_in = S_HALVE;
            end
         end
         S_HALVE: begin
            we.link    = 1'b1;
            link_waddr = x_ff;
            link_wdata = link_q;
            x_in       = link_q;
            rd_addr    = link_q;
            steps_in   = steps_ff + 1'b1;
            state_in   = S_LINK;
         end
         S_TOP: begin
            top_in   = top_q;
            rd_addr  = top_q;
            state_in = S_PAR;
         end
         S_PAR: begin
            if ((par_q == active_dim) && (32'(top_ff) != 32'(cur_row_ff))) begin
               we.par = 1'b1;
               we.top = 1'b1;
               if (rep_ff != cur_rep_ff) begin
                  we.link    = 1'b1;
                  link_waddr = rep_ff;
                  link_wdata = cur_rep_ff;
               end
               res_kind_in   = etp_pkg::KIND_ATTACH;
               res_child_in  = etp_pkg::index_type'(top_ff);
               res_parent_in = etp_pkg::count_type'(cur_row_ff);
               state_in      = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_QRY: begin
            res_parent_in = par_q;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = res_kind_ff;
               rsp_child_in  = res_child_ff;
               rsp_parent_in = res_parent_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_row_ff   <= '0;
         cur_rep_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_rep_ff   <= cur_rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      rep_ff        <= rep_in;
      top_ff        <= top_in;
      steps_ff      <= steps_in;
      res_kind_ff   <= res_kind_in;
      res_child_ff  <= res_child_in;
      res_parent_ff <= res_parent_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_child_ff  <= rsp_child_in;
      rsp_parent_ff <= rsp_parent_in;
   end

endmodule
`default_nettype wire

// ----- test/elimination_tree_parent_test.sv -----
`default_nettype none
module elimination_tree_parent_test;

   localparam int NODES = etp_pkg::DEF_MAX_NODES;
   localparam etp_pkg::action_type ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 2 * NODES + 16;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic               kind;
      etp_pkg::index_type child;
      etp_pkg::count_type parent;
   } tree_event_type;

   logic clock = 1'b0;
   logic reset;

   etp_req_if req_bus ();
   etp_rsp_if rsp_bus ();
   etp_csr_if csr_bus ();

   elimination_tree_parent u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the elimination tree and its union-find tables.
   etp_pkg::index_type link_mem [NODES];
   etp_pkg::index_type top_mem [NODES];
   etp_pkg::count_type parent_mem [NODES];
   bit        node_begun [NODES];
   int        begun_list [$];
   etp_pkg::index_type model_row = '0;
   etp_pkg::index_type model_rep = '0;
   etp_pkg::count_type model_active_dim = etp_pkg::ACTIVE_DIM_RESET;

   tree_event_type expected_events [$];
   int mismatches = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit steady_send = 1'b0;
   int hold_requests = 0;
   int holds_started = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int pattern_phase = 0;

   function automatic etp_pkg::index_type rnd_index();
      return etp_pkg::index_type'($urandom);
   endfunction

   function automatic etp_pkg::index_type find_root(etp_pkg::index_type start);
      etp_pkg::index_type x;
      etp_pkg::index_type up;
      int steps;
      x = start;
      steps = 0;
      while (steps < NODES) begin
         up = link_mem[x];
         if (up == x) break;
         link_mem[x] = link_mem[up];
         x = link_mem[x];
         steps++;
      end
      return x;
   endfunction

   task automatic apply_item(etp_pkg::action_type act, etp_pkg::index_type row,
                             etp_pkg::index_type col, etp_pkg::index_type node);
      etp_pkg::index_type rep;
      etp_pkg::index_type top;
      case (act)
         etp_pkg::ACT_BEGIN: begin
            if (row < model_active_dim) begin
               link_mem[row] = row;
               top_mem[row] = row;
               parent_mem[row] = model_active_dim;
               model_row = row;
               model_rep = row;
               if (!node_begun[row]) begin
                  node_begun[row] = 1'b1;
                  begun_list.push_back(row);
               end
            end
         end
         etp_pkg::ACT_ENTRY: begin
            if (col < model_row) begin
               rep = find_root(col);
               top = top_mem[rep];
               if (parent_mem[top] == model_active_dim && top != model_row) begin
                  parent_mem[top] = {1'b0, model_row};
                  if (rep != model_rep) link_mem[rep] = model_rep;
                  top_mem[model_rep] = model_row;
                  expected_events.push_back({etp_pkg::KIND_ATTACH, top, {1'b0, model_row}});
               end
            end
         end
         etp_pkg::ACT_READ: begin
            expected_events.push_back({etp_pkg::KIND_ANSWER, node, parent_mem[node]});
         end
         default: begin
         end
      endcase
   endtask

   function automatic int pick_begun_below(int bound);
      int c;
      repeat (6) begin
         c = begun_list[$urandom_range(0, begun_list.size() - 1)];
         if (c < bound) return c;
      end
      return -1;
   endfunction

   function automatic etp_pkg::index_type pick_begun();
      return etp_pkg::index_type'(begun_list[$urandom_range(0, begun_list.size() - 1)]);
   endfunction

   task automatic send_item(etp_pkg::action_type act, etp_pkg::index_type row,
                            etp_pkg::index_type col, etp_pkg::index_type node);
      if (!steady_send && burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.row_index <= row;
      req_bus.col_index <= col;
      req_bus.query_node <= node;
      do @(posedge clock); while (!req_bus.ready);
      apply_item(act, row, col, node);
      @(negedge clock);
   endtask

   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_active_dim(etp_pkg::count_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.active_dim <= value;
      do @(posedge clock); while (!csr_bus.ready);
      model_active_dim = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_results
      tree_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected item, child", rsp_bus.child_node, 0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_bus.kind !== want.kind)
               report_mismatch("kind", rsp_bus.kind, want.kind);
            if (rsp_bus.child_node !== want.child)
               report_mismatch("child_node", rsp_bus.child_node, want.child);
            if (rsp_bus.parent_node !== want.parent)
               report_mismatch("parent_node", rsp_bus.parent_node, want.parent);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (holds_started != hold_requests) begin
         holds_started = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         pattern_phase = (pattern_phase + 1) % 7;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: rsp_bus.ready <= (pattern_phase >= 3);
         endcase
      end
   end

   task automatic test_directed_tree();
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd1023, rnd_index());
      send_item(ACT_UNUSED, 10'd1023, 10'd1023, 10'd1023);
      send_item(etp_pkg::ACT_BEGIN, 10'd0, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_BEGIN, 10'd1, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd0, rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd0, rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd1, rnd_index());
      send_item(etp_pkg::ACT_BEGIN, 10'd3, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd0, rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd1, rnd_index());
      send_item(etp_pkg::ACT_BEGIN, 10'd1023, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd1023, rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd3, rnd_index());
      send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), 10'd0);
      send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), 10'd1);
      send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), 10'd3);
      send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), 10'd1023);
      send_item(etp_pkg::ACT_BEGIN, 10'd512, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd1, rnd_index());
      send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), 10'd1023);
   endtask

   // Parents stored under an earlier dimension no longer match the new
   // unattached value, so those subtree tops count as already attached.
   task automatic test_dimension_change();
      settle_block();
      write_active_dim(11'd1000);
      send_item(etp_pkg::ACT_BEGIN, 10'd2, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd0, rnd_index());
      send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), 10'd512);
      send_item(etp_pkg::ACT_BEGIN, 10'd999, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_BEGIN, 10'd1000, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), 10'd999);
      settle_block();
      write_active_dim(11'd1);
      send_item(etp_pkg::ACT_BEGIN, 10'd1, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_BEGIN, 10'd0, rnd_index(), rnd_index());
      send_item(etp_pkg::ACT_ENTRY, rnd_index(), 10'd0, rnd_index());
      send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), 10'd0);
   endtask

   task automatic test_random_rows(etp_pkg::count_type rows, int target);
      int produced;
      int stride;
      int r;
      int c;
      settle_block();
      write_active_dim(rows);
      stride = rows / 24 + 1;
      r = $urandom_range(0, stride - 1);
      produced = 0;
      while (produced < target) begin
         steady_send = ($urandom_range(0, 4) == 0);
         send_item(etp_pkg::ACT_BEGIN, etp_pkg::index_type'(r), rnd_index(), rnd_index());
         produced++;
         repeat ($urandom_range(0, 5)) begin
            c = pick_begun_below(r);
            if (c >= 0) begin
               send_item(etp_pkg::ACT_ENTRY, rnd_index(), etp_pkg::index_type'(c),
                         rnd_index());
               produced++;
            end
         end
         case ($urandom_range(0, 9))
            0: send_item(ACT_UNUSED, rnd_index(), rnd_index(), rnd_index());
            1: send_item(etp_pkg::ACT_ENTRY, rnd_index(),
                         etp_pkg::index_type'($urandom_range(model_row, NODES - 1)),
                         rnd_index());
            2: if (rows < NODES)
                  send_item(etp_pkg::ACT_BEGIN,
                            etp_pkg::index_type'($urandom_range(rows, NODES - 1)),
                            rnd_index(), rnd_index());
            3, 4, 5: begin
               send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), pick_begun());
               produced++;
            end
            6: begin
               send_item(etp_pkg::ACT_ENTRY, rnd_index(), pick_begun(), rnd_index());
               produced++;
            end
            default: begin
            end
         endcase
         r += $urandom_range(1, stride);
         if (r >= rows) r = $urandom_range(0, stride - 1);
      end
      steady_send = 1'b0;
   endtask

   task automatic test_output_backpressure();
      settle_block();
      write_active_dim(etp_pkg::ACTIVE_DIM_RESET);
      steady_send = 1'b1;
      hold_requests++;
      repeat (40) send_item(etp_pkg::ACT_READ, rnd_index(), rnd_index(), pick_begun());
      steady_send = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = etp_pkg::ACT_BEGIN;
      req_bus.row_index = '0;
      req_bus.col_index = '0;
      req_bus.query_node = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.active_dim = etp_pkg::ACTIVE_DIM_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_tree();
      test_dimension_change();
      test_random_rows(etp_pkg::ACTIVE_DIM_RESET, 110);
      test_random_rows(11'd2, 30);
      test_random_rows(etp_pkg::count_type'($urandom_range(3, NODES - 1)), 100);
      test_random_rows(11'd40, 80);
      test_output_backpressure();
      test_random_rows(etp_pkg::ACTIVE_DIM_RESET, 90);
      settle_block();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
